### hdl/rbvc_pkg.sv
package rbvc_pkg;

    // Geometry of the bitmap and the colour table
    localparam int BITMAP_COLUMNS_DEF = 224;
    localparam int LINE_PIXELS        = 256;
    localparam int COLUMN_BYTES       = LINE_PIXELS / 8;
    localparam int TABLE_ENTRIES      = 1024;
    localparam int TABLE_BASE         = 128;
    localparam int QUEUE_DEPTH        = 4;

    // Field widths
    localparam int POS_W     = $clog2(LINE_PIXELS);
    localparam int CBYTE_W   = $clog2(COLUMN_BYTES);
    localparam int BIT_W     = 3;
    localparam int TABLE_AW  = $clog2(TABLE_ENTRIES);
    localparam int COLOUR_W  = 3;
    localparam int REQ_W     = 2;
    localparam int ADDR_W    = 13;
    localparam int DATA_W    = 8;
    localparam int PIX_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    // Slave tdata layout, lowest bit first
    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = ROW_LSB + POS_W;
    localparam int WIN_LSB   = COL_LSB + POS_W;
    localparam int ADDR_LSB  = WIN_LSB + 1;
    localparam int WDATA_LSB = ADDR_LSB + ADDR_W;
    localparam int S_FIELDS_W = WDATA_LSB + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_RENDER   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_VRAM_WR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TABLE_WR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_RED = 2'd2;

    localparam logic [PIX_W-1:0] PIX_BLACK = 16'h0000;
    localparam logic [PIX_W-1:0] PIX_RED   = 16'hF800;

    typedef enum logic [1:0] {
        ROT_LANDSCAPE = 2'd0,
        ROT_CCW90     = 2'd1,
        ROT_180       = 2'd2,
        ROT_CW90      = 2'd3
    } rbvc_rot_t;

    typedef enum logic [1:0] {
        OP_RENDER   = 2'd0,
        OP_VRAM_WR  = 2'd1,
        OP_TABLE_WR = 2'd2
    } rbvc_op_t;

    // One queued command from the front to the back
    typedef struct packed {
        rbvc_op_t              op;
        logic [POS_W-1:0]      col;
        logic [CBYTE_W-1:0]    cbyte;
        logic [BIT_W-1:0]      bit_sel;
        logic [TABLE_AW-1:0]   table_addr;
        logic [DATA_W-1:0]     wdata;
        logic                  black;
        logic                  red;
    } rbvc_cmd_t;

    // 3-bit palette index to RGB565: bit 0 red, bit 1 blue, bit 2 green
    function automatic logic [PIX_W-1:0] pal565(input logic [COLOUR_W-1:0] idx);
        logic [PIX_W-1:0] pix;
        case (idx)
            3'd0:    pix = 16'h0000;
            3'd1:    pix = 16'hF800;
            3'd2:    pix = 16'h001F;
            3'd3:    pix = 16'hF81F;
            3'd4:    pix = 16'h07E0;
            3'd5:    pix = 16'hFFE0;
            3'd6:    pix = 16'h07FF;
            default: pix = 16'hFFFF;
        endcase
        return pix;
    endfunction

endpackage

### hdl/rbvc_ram.sv
module rbvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rbvc_front.sv
module rbvc_front
    import rbvc_pkg::*;
#(
    parameter int BITMAP_COLUMNS = BITMAP_COLUMNS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [REQ_W-1:0]      s_tuser,
    input  logic                  queue_full,
    input  logic                  clearing,
    output logic                  push,
    output rbvc_cmd_t             cmd
);

    localparam int VRAM_BYTES = BITMAP_COLUMNS * COLUMN_BYTES;
    localparam logic [POS_W-1:0] COL_LAST = POS_W'(BITMAP_COLUMNS - 1);

    rbvc_rot_t rotation_reg, rotation_next;
    logic      mirror_reg, mirror_next;
    logic      force_red_reg, force_red_next;

    logic [POS_W-1:0]  row_pos, col_pos;
    logic              in_window;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    logic [POS_W-1:0] line_c, sel, dx;
    logic             flip, in_range, keep;

    assign row_pos    = s_tdata[ROW_LSB +: POS_W];
    assign col_pos    = s_tdata[COL_LSB +: POS_W];
    assign in_window  = s_tdata[WIN_LSB];
    assign address    = s_tdata[ADDR_LSB +: ADDR_W];
    assign write_data = s_tdata[WDATA_LSB +: DATA_W];

    // Configuration registers
    always_comb begin
        rotation_next  = rotation_reg;
        mirror_next    = mirror_reg;
        force_red_next = force_red_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROTATION:  rotation_next  = rbvc_rot_t'(cfg_wr_data[1:0]);
                CFG_MIRROR:    mirror_next    = cfg_wr_data[0];
                CFG_FORCE_RED: force_red_next = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg  <= ROT_LANDSCAPE;
            mirror_reg    <= 1'b0;
            force_red_reg <= 1'b0;
        end else begin
            rotation_reg  <= rotation_next;
            mirror_reg    <= mirror_next;
            force_red_reg <= force_red_next;
        end
    end

    // Map source positions to bitmap line and column
    always_comb begin
        unique case (rotation_reg)
            ROT_LANDSCAPE: begin
                line_c = ~row_pos;
                sel    = col_pos;
                flip   = mirror_reg;
            end
            ROT_CCW90: begin
                line_c = col_pos;
                sel    = row_pos;
                flip   = mirror_reg;
            end
            ROT_180: begin
                line_c = row_pos;
                sel    = col_pos;
                flip   = !mirror_reg;
            end
            default: begin
                line_c = ~col_pos;
                sel    = row_pos;
                flip   = !mirror_reg;
            end
        endcase
    end

    assign in_range = {1'b0, sel} < (POS_W + 1)'(BITMAP_COLUMNS);
    assign dx       = flip ? COL_LAST - sel : sel;

    // Classify the beat and build its command
    always_comb begin
        cmd  = '0;
        keep = 1'b0;
        case (s_tuser)
            REQ_RENDER: begin
                keep           = 1'b1;
                cmd.op         = OP_RENDER;
                cmd.black      = !in_window || !in_range;
                cmd.red        = force_red_reg;
                cmd.col        = in_range ? dx : '0;
                cmd.cbyte      = line_c[POS_W-1 -: CBYTE_W];
                cmd.bit_sel    = line_c[BIT_W-1:0];
                cmd.table_addr = TABLE_AW'(TABLE_BASE)
                               + {dx[POS_W-1 -: (TABLE_AW - CBYTE_W)],
                                  line_c[POS_W-1 -: CBYTE_W]};
            end
            REQ_VRAM_WR: begin
                keep      = {1'b0, address} < (ADDR_W + 1)'(VRAM_BYTES);
                cmd.op    = OP_VRAM_WR;
                cmd.col   = address[ADDR_W-1 -: POS_W];
                cmd.cbyte = address[CBYTE_W-1:0];
                cmd.wdata = write_data;
            end
            REQ_TABLE_WR: begin
                keep           = address < ADDR_W'(TABLE_ENTRIES);
                cmd.op         = OP_TABLE_WR;
                cmd.table_addr = address[TABLE_AW-1:0];
                cmd.wdata      = write_data;
            end
            default: ;
        endcase
    end

    assign s_tready = !queue_full && !clearing;
    assign push     = s_tvalid && s_tready && keep;

endmodule

### hdl/rbvc_queue.sv
module rbvc_queue
    import rbvc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  rbvc_cmd_t push_cmd,
    input  logic      pop,
    output logic      q_valid,
    output logic      q_full,
    output rbvc_cmd_t head_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    rbvc_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0]     rd_ptr_reg, rd_ptr_next;

    assign q_valid  = wr_ptr_reg != rd_ptr_reg;
    assign q_full   = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W])
                   && (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign head_cmd = entry_reg[rd_ptr_reg[PTR_W-1:0]];

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg[PTR_W-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

### hdl/rbvc_back.sv
module rbvc_back
    import rbvc_pkg::*;
#(
    parameter int BITMAP_COLUMNS = BITMAP_COLUMNS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  rbvc_cmd_t        head_cmd,
    output logic             pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata
);

    localparam int VRAM_DEPTH = BITMAP_COLUMNS * COLUMN_BYTES;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam logic [VRAM_AW-1:0] VRAM_LAST = VRAM_AW'(VRAM_DEPTH - 1);

    logic                clearing_reg, clearing_next;
    logic [VRAM_AW-1:0]  clr_addr_reg, clr_addr_next;

    logic                s2_valid_reg, s2_valid_next;
    logic                s2_black_reg, s2_red_reg;
    logic [BIT_W-1:0]    s2_bit_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0]    m_tdata_reg;

    logic                out_free, s2_free, s2_move, take_render;
    logic [POS_W+CBYTE_W-1:0] cmd_byte_addr;
    logic [VRAM_AW-1:0]  vram_addr, vram_waddr;
    logic                vram_we, table_we;
    logic [DATA_W-1:0]   vram_wdata, vram_rdata;
    logic [COLOUR_W-1:0] table_rdata;
    logic [PIX_W-1:0]    pixel;

    // Pop a write whenever one is queued; a render needs room in stage two
    assign out_free    = !m_tvalid_reg || m_tready;
    assign s2_free     = !s2_valid_reg || out_free;
    assign s2_move     = s2_valid_reg && out_free;
    assign pop         = q_valid && !clearing_reg
                      && (head_cmd.op != OP_RENDER || s2_free);
    assign take_render = pop && head_cmd.op == OP_RENDER;

    assign cmd_byte_addr = {head_cmd.col, head_cmd.cbyte};
    assign vram_addr     = cmd_byte_addr[VRAM_AW-1:0];

    // Clearing pass sweeps the bitmap after reset
    assign vram_we    = clearing_reg || (pop && head_cmd.op == OP_VRAM_WR);
    assign vram_waddr = clearing_reg ? clr_addr_reg : vram_addr;
    assign vram_wdata = clearing_reg ? '0 : head_cmd.wdata;
    assign table_we   = pop && head_cmd.op == OP_TABLE_WR;

    rbvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .aclk  (aclk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (take_render),
        .raddr (vram_addr),
        .rdata (vram_rdata)
    );

    rbvc_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (table_we),
        .waddr (head_cmd.table_addr),
        .wdata (head_cmd.wdata[COLOUR_W-1:0]),
        .re    (take_render),
        .raddr (head_cmd.table_addr),
        .rdata (table_rdata)
    );

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == VRAM_LAST) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (take_render) begin
            s2_valid_next = 1'b1;
        end else if (s2_move) begin
            s2_valid_next = 1'b0;
        end
    end

    always_comb begin
        if (s2_black_reg || !vram_rdata[s2_bit_reg]) begin
            pixel = PIX_BLACK;
        end else if (s2_red_reg) begin
            pixel = PIX_RED;
        end else begin
            pixel = pal565(table_rdata);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s2_move) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_render) begin
            s2_black_reg <= head_cmd.black;
            s2_red_reg   <= head_cmd.red;
            s2_bit_reg   <= head_cmd.bit_sel;
        end
        if (s2_move) begin
            m_tdata_reg <= pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s2_valid_reg <= s2_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign clearing = clearing_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !pop)
        else $error("command popped during clearing pass");

    a_s2_room: assert property (@(posedge aclk) disable iff (!aresetn)
        take_render |-> (!s2_valid_reg || out_free))
        else $error("render loaded over a stalled stage two");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s2_valid_reg))
        else $error("output beat raised without a stage-two pixel");

endmodule

### hdl/rotated_bitmap_video_colorizer_unit.sv
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: req_type[1:0]
//                tdata: row_pos[7:0] col_pos[15:8] in_window[16]
//                       address[29:17] write_data[37:30] zero[39:38]
// m_axis    out  tdata: pixel_rgb565[15:0]
// cfg       in   cfg_wr_en, cfg_index (0 rotation, 1 mirror, 2 force_red), cfg_wr_data
//
// One beat is taken per clock while s_tready is high; a render beat's pixel
// passes the command queue, the registered bitmap and colour table read and
// the output register before it is offered on m_tdata.
// Writes give no output beat and retire in the cycle they are popped.
// After reset the bitmap, BITMAP_COLUMNS*32 bytes (7168 at the default size),
// is swept to zero, one byte a cycle; s_tready stays low meanwhile, while
// configuration writes are still taken.
// A stall on m_tready fills the four-entry command queue before s_tready drops.
module rotated_bitmap_video_colorizer_unit
    import rbvc_pkg::*;
#(
    parameter int BITMAP_COLUMNS = BITMAP_COLUMNS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row_pos, col_pos, in_window, address, write_data, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [REQ_W-1:0]     s_tuser,
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_rgb565
    output logic [PIX_W-1:0]     m_tdata
);

    rbvc_cmd_t push_cmd, head_cmd;
    logic      push, pop, q_valid, q_full, clearing;

    // Front: hold config, map positions, drop ignored beats
    rbvc_front #(
        .BITMAP_COLUMNS (BITMAP_COLUMNS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .queue_full  (q_full),
        .clearing    (clearing),
        .push        (push),
        .cmd         (push_cmd)
    );

    // Queue: decouple the front from output stalls
    rbvc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head_cmd (head_cmd)
    );

    // Back: perform store writes, read bitmap and colour table, colour the pixel
    rbvc_back #(
        .BITMAP_COLUMNS (BITMAP_COLUMNS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .head_cmd (head_cmd),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### bench/rotated_bitmap_video_colorizer_unit_test.sv
`timescale 1ns / 100ps

module rotated_bitmap_video_colorizer_unit_test;
    import rbvc_pkg::*;

    localparam int BITMAP_COLUMNS  = BITMAP_COLUMNS_DEF;
    localparam int VRAM_BYTES      = BITMAP_COLUMNS * COLUMN_BYTES;
    localparam int NUM_DIRECTED    = 21;
    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 69;
    localparam int RECENT_DEPTH    = 64;
    // queue read plus registered bitmap read, plus the four-entry queue, with margin
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 150;
    // the bitmap sweep after reset clears all 7168 bytes while no beat moves
    localparam int WATCHDOG_LIMIT  = 30000;

    // req_type 3 has no meaning; the block must drop it without a result
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    // palette index to RGB565, index 0 in the lowest bits
    localparam logic [7:0][PIX_W-1:0] PALETTE_RGB565 = {
        16'hFFFF, 16'h07FF, 16'hFFE0, 16'h07E0, 16'hF81F, 16'h001F, 16'hF800, 16'h0000
    };

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              win;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } colour_req_t;

    typedef struct packed {
        colour_req_t      beat;
        logic             typed;   // 1: pix holds the known answer
        logic [PIX_W-1:0] pix;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;

    // Shadow state of the block: bitmap, colour table and registers
    logic [7:0]          video_bytes   [VRAM_BYTES];
    logic [COLOUR_W-1:0] colour_index  [TABLE_ENTRIES];
    bit                  entry_written [TABLE_ENTRIES];
    rbvc_rot_t           cur_rot;
    logic                cur_mirror;
    logic                cur_red;

    logic [PIX_W-1:0] expected_pixels [$];
    directed_row_t    directed_rows [NUM_DIRECTED];

    int  mismatches     = 0;
    int  pixels_checked = 0;
    int  beats_sent     = 0;
    int  settings_run   = 0;
    bit  steady         = 1'b0;   // 1: neither side idles
    int  hold_asks      = 0;
    int  hold_done      = 0;

    rotated_bitmap_video_colorizer_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Follow a render beat through rotation and mirror down to the bitmap bit.
    // Return the bit, and the colour table entry that a lit pixel would read.
    function automatic logic trace_pixel(input logic [POS_W-1:0] rpos,
                                         input logic [POS_W-1:0] cpos,
                                         input logic win,
                                         output logic [TABLE_AW-1:0] entry);
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] sel;
        logic             flip;
        int               dx;
        entry = '0;
        case (cur_rot)
            ROT_LANDSCAPE: begin line = 8'd255 - rpos; sel = cpos; flip = cur_mirror;  end
            ROT_CCW90:     begin line = cpos;          sel = rpos; flip = cur_mirror;  end
            ROT_180:       begin line = rpos;          sel = cpos; flip = !cur_mirror; end
            default:       begin line = 8'd255 - cpos; sel = rpos; flip = !cur_mirror; end
        endcase
        // outside the window, or a column past the right edge of the bitmap
        if (!win || int'(sel) >= BITMAP_COLUMNS)
            return 1'b0;
        dx    = flip ? BITMAP_COLUMNS - 1 - int'(sel) : int'(sel);
        entry = TABLE_AW'((TABLE_BASE + 32 * (dx / 8) + int'(line[7:3])) % TABLE_ENTRIES);
        return video_bytes[dx * COLUMN_BYTES + int'(line[7:3])][line[2:0]];
    endfunction

    function automatic logic [PIX_W-1:0] expected_pixel(input colour_req_t b);
        logic [TABLE_AW-1:0] entry;
        logic                lit;
        lit = trace_pixel(b.row, b.col, b.win, entry);
        if (!lit)
            return PIX_BLACK;
        if (cur_red)
            return PIX_RED;
        return PALETTE_RGB565[colour_index[entry]];
    endfunction

    // Offer one beat, idling first at random; on acceptance apply it to the shadow
    // state. Enter and leave on a falling edge.
    task automatic send_beat(input colour_req_t b, input logic typed,
                             input logic [PIX_W-1:0] typed_pix);
        while (!steady && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.req;
        s_tdata  <= {2'b00, b.data, b.addr, b.win, b.col, b.row};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        case (b.req)
            REQ_RENDER:
                expected_pixels.push_back(typed ? typed_pix : expected_pixel(b));
            REQ_VRAM_WR:
                if (int'(b.addr) < VRAM_BYTES)
                    video_bytes[b.addr] = b.data;
            REQ_TABLE_WR:
                if (int'(b.addr) < TABLE_ENTRIES) begin
                    colour_index[b.addr[TABLE_AW-1:0]]  = b.data[COLOUR_W-1:0];
                    entry_written[b.addr[TABLE_AW-1:0]] = 1'b1;
                end
            default: ;
        endcase
        beats_sent++;
        @(negedge aclk);
    endtask

    // Drop tvalid, wait for every pixel owed, then let the pipeline empty out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers on consecutive cycles; only while idle
    task automatic apply_settings(input rbvc_rot_t rot, input logic mir, input logic red);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_ROTATION;
        cfg_wr_data <= CFG_DAT_W'(rot);
        @(negedge aclk);
        cfg_index   <= CFG_MIRROR;
        cfg_wr_data <= CFG_DAT_W'(mir);
        @(negedge aclk);
        cfg_index   <= CFG_FORCE_RED;
        cfg_wr_data <= CFG_DAT_W'(red);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_rot      = rot;
        cur_mirror   = mir;
        cur_red      = red;
        settings_run++;
    endtask

    // Receiver: random back-pressure, or a long hold-off when the sender asks
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done++;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    // Check every pixel beat against the oldest pixel still owed
    always @(posedge aclk) begin
        logic [PIX_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                $error("pixel_rgb565: no pixel expected, got %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want) begin
                    $error("pixel_rgb565: expected %h, got %h", want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // End the run if no beat moves on either side for too long
    initial begin : watchdog
        int quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL rotated_bitmap_video_colorizer_unit");
        $finish;
    end

    initial begin
        colour_req_t         b;
        colour_req_t         pre;
        logic [TABLE_AW-1:0] entry;
        logic                flip;
        int                  roll;
        int                  pick;
        int                  dx;
        int                  line;
        int                  sel;
        int                  recent_vram [$];

        // Hold every input at a known value from time zero
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_ROTATION;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_RENDER;
        cur_rot     = ROT_LANDSCAPE;
        cur_mirror  = 1'b0;
        cur_red     = 1'b0;
        foreach (video_bytes[i])   video_bytes[i]   = 8'h00;
        foreach (colour_index[i])  colour_index[i]  = '0;
        foreach (entry_written[i]) entry_written[i] = 1'b0;

        // Directed beats, reset settings: landscape, no mirror, colour.
        // Column 0 line 0 sits in byte 0 bit 0 and reads entry 128;
        // column 223 line 255 sits in byte 7167 bit 7 and reads entry 1023.
        directed_rows = '{
            // bitmap cleared by reset
            '{'{REQ_RENDER,   8'd0,   8'd0,   1'b1, 13'd0,    8'h00}, 1'b1, PIX_BLACK},
            // column past the bitmap
            '{'{REQ_RENDER,   8'd255, 8'd255, 1'b1, 13'd0,    8'h00}, 1'b1, PIX_BLACK},
            '{'{REQ_VRAM_WR,  8'd0,   8'd0,   1'b0, 13'd0,    8'hFF}, 1'b0, PIX_BLACK},
            // the table keeps the low three bits: white
            '{'{REQ_TABLE_WR, 8'd0,   8'd0,   1'b0, 13'd128,  8'hFF}, 1'b0, PIX_BLACK},
            '{'{REQ_RENDER,   8'd255, 8'd0,   1'b1, 13'd0,    8'h00}, 1'b1, 16'hFFFF},
            // lit but outside the window
            '{'{REQ_RENDER,   8'd255, 8'd0,   1'b0, 13'd0,    8'h00}, 1'b1, PIX_BLACK},
            // first column past the right edge
            '{'{REQ_RENDER,   8'd255, 8'd224, 1'b1, 13'd0,    8'h00}, 1'b1, PIX_BLACK},
            '{'{REQ_VRAM_WR,  8'd0,   8'd0,   1'b0, 13'd7167, 8'h80}, 1'b0, PIX_BLACK},
            '{'{REQ_TABLE_WR, 8'd0,   8'd0,   1'b0, 13'd1023, 8'h01}, 1'b0, PIX_BLACK},
            '{'{REQ_RENDER,   8'd0,   8'd223, 1'b1, 13'd0,    8'h00}, 1'b1, PIX_RED},
            // writes past the end of either store are dropped
            '{'{REQ_VRAM_WR,  8'd0,   8'd0,   1'b0, 13'd7168, 8'hFF}, 1'b0, PIX_BLACK},
            '{'{REQ_VRAM_WR,  8'd0,   8'd0,   1'b0, 13'd8191, 8'hFF}, 1'b0, PIX_BLACK},
            '{'{REQ_TABLE_WR, 8'd0,   8'd0,   1'b0, 13'd1152, 8'h00}, 1'b0, PIX_BLACK},
            '{'{REQ_TABLE_WR, 8'd255, 8'd255, 1'b1, 13'd8191, 8'h00}, 1'b0, PIX_BLACK},
            // unknown request: no pixel, no write
            '{'{REQ_UNKNOWN,  8'd255, 8'd255, 1'b1, 13'd128,  8'h00}, 1'b0, PIX_BLACK},
            '{'{REQ_RENDER,   8'd255, 8'd0,   1'b1, 13'd0,    8'h00}, 1'b1, 16'hFFFF},
            '{'{REQ_RENDER,   8'd0,   8'd223, 1'b1, 13'd0,    8'h00}, 1'b0, PIX_BLACK},
            '{'{REQ_RENDER,   8'd254, 8'd0,   1'b1, 13'd0,    8'h00}, 1'b0, PIX_BLACK},
            '{'{REQ_VRAM_WR,  8'd0,   8'd0,   1'b0, 13'd0,    8'h00}, 1'b0, PIX_BLACK},
            '{'{REQ_RENDER,   8'd255, 8'd0,   1'b1, 13'd0,    8'h00}, 1'b1, PIX_BLACK},
            '{'{REQ_RENDER,   8'd255, 8'd255, 1'b0, 13'd0,    8'h00}, 1'b1, PIX_BLACK}
        };

        // Reset once; the registers may be written while the bitmap sweep runs
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        apply_settings(ROT_LANDSCAPE, 1'b0, 1'b0);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].pix);
        drain();

        // Random phases: each pass of rotation, mirror and red, extremes included
        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_settings(rbvc_rot_t'(p[1:0]), p[2], p[3]);
            steady = (p == 5);
            // long receiver hold-off while beats keep coming: the queue fills
            if (p == 2)
                hold_asks++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll   = $urandom_range(99);
                b.row  = POS_W'($urandom);
                b.col  = POS_W'($urandom);
                b.win  = ($urandom_range(99) < 85);
                b.addr = ADDR_W'($urandom);
                b.data = DATA_W'($urandom);
                if (roll < 22) begin
                    b.req = REQ_VRAM_WR;
                    if ($urandom_range(9) != 0)
                        b.addr = ADDR_W'($urandom_range(VRAM_BYTES - 1));
                    if (int'(b.addr) < VRAM_BYTES) begin
                        recent_vram.push_back(int'(b.addr));
                        if (recent_vram.size() > RECENT_DEPTH)
                            void'(recent_vram.pop_front());
                    end
                end else if (roll < 32) begin
                    b.req = REQ_TABLE_WR;
                    if ($urandom_range(9) != 0)
                        b.addr = ADDR_W'($urandom_range(TABLE_ENTRIES - 1, TABLE_BASE));
                end else if (roll < 35) begin
                    b.req = REQ_UNKNOWN;
                end else begin
                    b.req = REQ_RENDER;
                    // aim most renders at a byte written lately, so pixels light up
                    if (recent_vram.size() != 0 && $urandom_range(99) < 70) begin
                        pick = recent_vram[$urandom_range(recent_vram.size() - 1)];
                        dx   = pick / COLUMN_BYTES;
                        line = (pick % COLUMN_BYTES) * 8 + $urandom_range(7);
                        flip = (cur_rot == ROT_LANDSCAPE || cur_rot == ROT_CCW90) ?
                               cur_mirror : !cur_mirror;
                        sel  = flip ? BITMAP_COLUMNS - 1 - dx : dx;
                        case (cur_rot)
                            ROT_LANDSCAPE: begin b.col = POS_W'(sel); b.row = POS_W'(255 - line); end
                            ROT_CCW90:     begin b.row = POS_W'(sel); b.col = POS_W'(line);       end
                            ROT_180:       begin b.col = POS_W'(sel); b.row = POS_W'(line);       end
                            default:       begin b.row = POS_W'(sel); b.col = POS_W'(255 - line); end
                        endcase
                    end
                    // never let a lit pixel read a table entry that holds nothing yet
                    if (trace_pixel(b.row, b.col, b.win, entry) && !cur_red &&
                        !entry_written[entry]) begin
                        pre      = b;
                        pre.req  = REQ_TABLE_WR;
                        pre.addr = ADDR_W'(entry);
                        pre.data = DATA_W'($urandom);
                        send_beat(pre, 1'b0, PIX_BLACK);
                    end
                end
                send_beat(b, 1'b0, PIX_BLACK);
            end
            drain();
        end
        steady = 1'b0;

        $display("Run covered %0d input beats and %0d pixel beats under %0d register settings,",
                 beats_sent, pixels_checked, settings_run);
        $display("all four rotations with and without mirror, in colour and forced red.");
        if (mismatches == 0)
            $display("PASS rotated_bitmap_video_colorizer_unit");
        else
            $display("FAIL rotated_bitmap_video_colorizer_unit");
        $finish;
    end

endmodule
